### rtl/core/cpt_pkg.sv
// Shared types and constants for the convex polygon point test block.
package cpt_pkg;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [33:0] prod_t;
  typedef logic signed [34:0] sum_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam int unsigned MinVertices     = 3;
  localparam int unsigned TriangleEdges   = 3;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // valid and enable flags for the three-vertex window handed to the edge unit
  typedef struct packed {
    logic vld;
    logic edge_en;
    logic conc_en;
  } win_t;

  typedef struct packed {
    logic vld;
    logic busy;
    logic edge_neg;
    logic conc_pos;
  } res_t;

endpackage

### rtl/core/cpt_in_if.sv
// Input channel: operation and coordinates.
interface cpt_in_if;
  logic         valid;
  logic         ready;
  logic [1:0]   operation;
  cpt_pkg::coord_t coord_x;
  cpt_pkg::coord_t coord_y;

  modport source (output valid, output operation, output coord_x, output coord_y,
                  input ready);
  modport sink   (input valid, input operation, input coord_x, input coord_y,
                  output ready);
endinterface

### rtl/core/cpt_out_if.sv
// Output channel: test result, concavity, status and vertex count.
interface cpt_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic       is_concave;
  logic [1:0] status;
  logic [4:0] count_now;

  modport source (output valid, output inside_res, output is_concave, output status,
                  output count_now, input ready);
  modport sink   (input valid, input inside_res, input is_concave, input status,
                  input count_now, output ready);
endinterface

### rtl/core/cpt_edge_unit.sv
// Pipelined edge-function and vertex cross-product evaluator (diff, multiply, compare).
module cpt_edge_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpt_pkg::win_t    win_i,
  input  cpt_pkg::vertex_t pp_i,
  input  cpt_pkg::vertex_t prv_i,
  input  cpt_pkg::vertex_t cur_i,
  input  cpt_pkg::coord_t  px_i,
  input  cpt_pkg::coord_t  py_i,
  output cpt_pkg::res_t    res_o
);

  // stage 1: differences
  logic            dif_vld_q, dif_edge_q, dif_conc_q;
  cpt_pkg::diff_t  ex_q, ey_q, fy_q, fx_q, cax_q, bcy_q, bcx_q, cay_q;
  // stage 2: products
  logic            prd_vld_q, prd_edge_q, prd_conc_q;
  cpt_pkg::prod_t  p0_q, p1_q, p2_q, p3_q;
  // stage 3: signs
  logic            res_vld_q, neg_q, pos_q;
  cpt_pkg::sum_t   f_val, m_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_vld_q <= 1'b0;
      prd_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      dif_vld_q <= win_i.vld;
      prd_vld_q <= dif_vld_q;
      res_vld_q <= prd_vld_q;
    end
  end

  // edge prv->cur against point; cross product at prv with pred pp and succ cur
  always_ff @(posedge clk_i) begin
    dif_edge_q <= win_i.edge_en;
    dif_conc_q <= win_i.conc_en;
    ex_q  <= cpt_pkg::diff_t'(cur_i.x) - cpt_pkg::diff_t'(prv_i.x);
    ey_q  <= cpt_pkg::diff_t'(py_i)    - cpt_pkg::diff_t'(prv_i.y);
    fy_q  <= cpt_pkg::diff_t'(cur_i.y) - cpt_pkg::diff_t'(prv_i.y);
    fx_q  <= cpt_pkg::diff_t'(px_i)    - cpt_pkg::diff_t'(prv_i.x);
    cax_q <= cpt_pkg::diff_t'(prv_i.x) - cpt_pkg::diff_t'(cur_i.x);
    bcy_q <= cpt_pkg::diff_t'(pp_i.y)  - cpt_pkg::diff_t'(prv_i.y);
    bcx_q <= cpt_pkg::diff_t'(pp_i.x)  - cpt_pkg::diff_t'(prv_i.x);
    cay_q <= cpt_pkg::diff_t'(prv_i.y) - cpt_pkg::diff_t'(cur_i.y);
  end

  always_ff @(posedge clk_i) begin
    prd_edge_q <= dif_edge_q;
    prd_conc_q <= dif_conc_q;
    p0_q <= ex_q * ey_q;
    p1_q <= fy_q * fx_q;
    p2_q <= cax_q * bcy_q;
    p3_q <= bcx_q * cay_q;
  end

  always_comb begin
    f_val = cpt_pkg::sum_t'(p0_q) - cpt_pkg::sum_t'(p1_q);
    m_val = cpt_pkg::sum_t'(p2_q) - cpt_pkg::sum_t'(p3_q);
  end

  always_ff @(posedge clk_i) begin
    neg_q <= prd_edge_q && f_val[34];
    pos_q <= prd_conc_q && !m_val[34] && (m_val != '0);
  end

  assign res_o.vld      = res_vld_q;
  assign res_o.busy     = dif_vld_q | prd_vld_q;
  assign res_o.edge_neg = neg_q;
  assign res_o.conc_pos = pos_q;

endmodule

### rtl/core/convex_polygon_point_test.sv
// Top level of the convex polygon point test block.
// Vertices (counter-clockwise) sit in a one-port synchronous table of MAX_VERTICES
// entries. Clear, append and unknown operations, and a test with fewer than
// three stored vertices, finish without a table read. A point test with n >= 3
// stored vertices streams n + 2 table reads through a three-vertex window and a
// three-stage multiply pipeline. The result is held in an output register, so a
// new item is taken as soon as the previous result is taken or in the same cycle.
module convex_polygon_point_test #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpt_in_if.sink     in_i,
  cpt_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW = $clog2(MAX_VERTICES + 2);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  cpt_pkg::vertex_t mem_q [MAX_VERTICES];
  cpt_pkg::vertex_t rdata_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] seq_q, seq_d, rd_seq_q, win_seq_q;
  logic [AW-1:0] addr_q, addr_d;
  logic          rd_en, rd_vld_q, win_vld_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  cpt_pkg::coord_t  px_q, py_q;
  cpt_pkg::vertex_t cur_q, prv_q, pp_q;
  cpt_pkg::win_t    win;
  cpt_pkg::res_t    res;

  logic inside_q, inside_d, conc_q, conc_d;
  logic in_acc, test_start, done;

  logic       out_vld_q, out_vld_d;
  logic       out_in_q, out_in_d, out_cc_q, out_cc_d;
  logic [1:0] out_st_q, out_st_d;
  logic [4:0] out_cnt_q, out_cnt_d;

  assign in_i.ready = (state_q == S_IDLE) && (!out_vld_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign test_start = in_acc && (in_i.operation == cpt_pkg::OP_TEST) &&
                      (cnt_q >= CW'(cpt_pkg::MinVertices));
  assign wr_en      = in_acc && (in_i.operation == cpt_pkg::OP_APPEND) &&
                      (cnt_q != CW'(MAX_VERTICES));
  assign wr_addr    = cnt_q[AW-1:0];
  assign rd_en      = (state_q == S_READ);
  assign done       = (state_q == S_DRAIN) && !rd_vld_q && !win_vld_q &&
                      !res.busy && !res.vld;

  // vertex table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= '{x: in_i.coord_x, y: in_i.coord_y};
    end
    if (rd_en) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    seq_d     = seq_q;
    addr_d    = addr_q;
    inside_d  = inside_q;
    conc_d    = conc_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_in_d  = out_in_q;
    out_cc_d  = out_cc_q;
    out_st_d  = out_st_q;
    out_cnt_d = out_cnt_q;

    if (res.vld) begin
      if (res.edge_neg) inside_d = 1'b0;
      if (res.conc_pos) conc_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_in_d = 1'b0;
          out_cc_d = 1'b0;
          out_st_d = cpt_pkg::ST_OK;
          case (in_i.operation)
            cpt_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            cpt_pkg::OP_APPEND: begin
              if (cnt_q == CW'(MAX_VERTICES)) out_st_d = cpt_pkg::ST_FULL;
              else cnt_d = cnt_q + CW'(1);
            end
            cpt_pkg::OP_TEST: begin
              if (!test_start) out_st_d = cpt_pkg::ST_FEW;
            end
            default: ;
          endcase
          out_cnt_d = 5'(cnt_d);
          if (test_start) begin
            state_d  = S_READ;
            seq_d    = '0;
            addr_d   = '0;
            inside_d = 1'b1;
            conc_d   = 1'b0;
          end else begin
            out_vld_d = 1'b1;
          end
        end
      end
      S_READ: begin
        // reads walk 0..n-1 then 0, 1 again to close the ring
        seq_d  = seq_q + SW'(1);
        addr_d = (CW'(addr_q) == cnt_q - CW'(1)) ? '0 : addr_q + AW'(1);
        if (seq_q == SW'(cnt_q) + SW'(1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (done) begin
          state_d   = S_IDLE;
          out_vld_d = 1'b1;
          out_in_d  = inside_q;
          out_cc_d  = conc_q && (cnt_q > CW'(cpt_pkg::TriangleEdges));
          out_st_d  = cpt_pkg::ST_OK;
          out_cnt_d = 5'(cnt_q);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      win_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_en;
      win_vld_q <= rd_vld_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q     <= seq_d;
    addr_q    <= addr_d;
    inside_q  <= inside_d;
    conc_q    <= conc_d;
    out_in_q  <= out_in_d;
    out_cc_q  <= out_cc_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
    rd_seq_q  <= seq_q;
    if (in_acc) begin
      px_q <= in_i.coord_x;
      py_q <= in_i.coord_y;
    end
    // sliding window of the last three vertices read
    if (rd_vld_q) begin
      cur_q     <= rdata_q;
      prv_q     <= cur_q;
      pp_q      <= prv_q;
      win_seq_q <= rd_seq_q;
    end
  end

  assign win.vld     = win_vld_q;
  assign win.edge_en = (win_seq_q != '0);
  assign win.conc_en = (win_seq_q >= SW'(2));

  cpt_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win),
    .pp_i   (pp_q),
    .prv_i  (prv_q),
    .cur_i  (cur_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .res_o  (res)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.inside_res = out_in_q;
  assign out_o.is_concave = out_cc_q;
  assign out_o.status     = out_st_q;
  assign out_o.count_now  = out_cnt_q;

endmodule
